// File: design/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and character mapping for the base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam int MAX_RESULTS     = 8;
    localparam int RES_CNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_BITS    = $clog2(MAX_RESULTS);
    localparam int COLUMN_BITS_DEF = 10;

    localparam int WRAP_BITS      = 10;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;

    localparam logic [WRAP_BITS-1:0] WRAP_RESET = 10'd76;

    // register indices
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECODE_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WRAP_COLUMNS   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IGNORE_GARBAGE = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_BAD_CHAR   = 2'd1;
    localparam logic [1:0] STAT_INCOMPLETE = 2'd2;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_NL  = 8'h0A;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic [1:0] status;
    } res_entry_t;

    typedef struct packed {
        logic                                load;
        logic [RES_CNT_BITS-1:0]             count;
        res_entry_t [MAX_RESULTS-1:0]        entries;
    } res_load_t;

    // sextet value to alphabet character
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        priority if (v < 6'd26)
            c = 8'd65 + 8'(v);
        else if (v < 6'd52)
            c = 8'd97 + 8'(v - 6'd26);
        else if (v < 6'd62)
            c = 8'd48 + 8'(v - 6'd52);
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

    // alphabet character to {hit, sextet}
    function automatic logic [6:0] char_sextet(input logic [7:0] c);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'd0;
        r = 7'd0;
        priority if (c >= 8'd65 && c <= 8'd90)
        begin
            t = c - 8'd65;
            r = {1'b1, t[5:0]};
        end
        else if (c >= 8'd97 && c <= 8'd122)
        begin
            t = c - 8'd71;
            r = {1'b1, t[5:0]};
        end
        else if (c >= 8'd48 && c <= 8'd57)
        begin
            t = c + 8'd4;
            r = {1'b1, t[5:0]};
        end
        else if (c == 8'h2B)
            r = {1'b1, 6'd62};
        else if (c == 8'h2F)
            r = {1'b1, 6'd63};
        else
            r = 7'd0;
        return r;
    endfunction

endpackage

// File: design/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 encoder/decoder over a byte stream with line wrapping on encode.
// ----------------------------------------------------------------------------
// An input is held in the input register; its result list then loads into the queue.
// Throughput: one input per cycle while each input gives at most one result and
//   out_ready stays high; otherwise one result per cycle while out_ready is high,
//   set by the single output port draining the result queue.
// Reset: rst_n is asynchronous; it empties the pipeline and the queue, clears
//   the group state and loads the register defaults (encode, wrap 76).
module base64_stream_codec #(
    parameter int COLUMN_BITS = b64sc_pkg::COLUMN_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [b64sc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [b64sc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            in_byte,
    input  logic                                  is_last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [7:0]                            out_byte,
    output logic                                  byte_valid,
    output logic [1:0]                            status,
    output logic                                  run_end
);

    // configuration
    logic                               decode_mode_reg;
    logic [b64sc_pkg::WRAP_BITS-1:0]    wrap_columns_reg;
    logic                               ignore_garbage_reg;
    logic [COLUMN_BITS-1:0]             wrap_eff;
    logic                               wrap_on;

    // input register
    logic                               item_valid_reg;
    logic [7:0]                         item_byte_reg;
    logic                               item_last_reg;
    logic                               item_take;

    // group state
    logic [23:0]                        group_bits_reg;
    logic [23:0]                        group_bits_next;
    logic [1:0]                         group_fill_reg;
    logic [1:0]                         group_fill_next;
    logic [1:0]                         pad_count_reg;
    logic [1:0]                         pad_count_next;
    logic [COLUMN_BITS-1:0]             line_column_reg;
    logic [COLUMN_BITS-1:0]             line_column_next;

    // step logic
    b64sc_pkg::res_entry_t [b64sc_pkg::MAX_RESULTS-1:0] res_list;
    logic [b64sc_pkg::RES_CNT_BITS-1:0] res_n;
    logic [1:0]                         fill_e;
    logic [1:0]                         fill_a;
    logic [7:0]                         ch;
    logic [6:0]                         sx;
    logic                               add;
    logic [5:0]                         add_v;
    logic [1:0]                         byte_cnt;
    b64sc_pkg::res_load_t               res_load;
    logic                               can_load;
    logic                               mode_clear;

    assign wrap_eff   = COLUMN_BITS'(wrap_columns_reg);
    assign wrap_on    = (wrap_eff != '0);
    assign mode_clear = cfg_write && (cfg_index == b64sc_pkg::REG_DECODE_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg    <= 1'b0;
            wrap_columns_reg   <= b64sc_pkg::WRAP_RESET;
            ignore_garbage_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                b64sc_pkg::REG_DECODE_MODE:    decode_mode_reg    <= cfg_data[0];
                b64sc_pkg::REG_WRAP_COLUMNS:   wrap_columns_reg   <= cfg_data;
                b64sc_pkg::REG_IGNORE_GARBAGE: ignore_garbage_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // an item with no results never waits for the queue
    assign item_take = item_valid_reg && ((res_n == '0) || can_load);
    assign in_ready  = !item_valid_reg || item_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_byte_reg <= in_byte;
            item_last_reg <= is_last;
        end
    end

    always_comb
    begin
        res_list         = '0;
        res_n            = '0;
        group_bits_next  = group_bits_reg;
        group_fill_next  = group_fill_reg;
        pad_count_next   = pad_count_reg;
        line_column_next = line_column_reg;
        fill_e           = 2'd0;
        fill_a           = 2'd0;
        ch               = 8'd0;
        sx               = b64sc_pkg::char_sextet(item_byte_reg);
        add              = 1'b0;
        add_v            = 6'd0;
        byte_cnt         = 2'd0;

        if (!decode_mode_reg)
        begin
            fill_e = (group_fill_reg > 2'd2) ? 2'd2 : group_fill_reg;
            unique case (fill_e)
                2'd0:    group_bits_next = group_bits_reg | {item_byte_reg, 16'h0};
                2'd1:    group_bits_next = group_bits_reg | {8'h0, item_byte_reg, 8'h0};
                default: group_bits_next = group_bits_reg | {16'h0, item_byte_reg};
            endcase
            fill_a          = fill_e + 2'd1;
            group_fill_next = fill_a;
            if (fill_a == 2'd3 || item_last_reg)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (k > int'(fill_a))
                        ch = b64sc_pkg::CHAR_PAD;
                    else
                        ch = b64sc_pkg::sextet_char(group_bits_next[23-6*k -: 6]);
                    res_list[res_n[b64sc_pkg::RES_IDX_BITS-1:0]] =
                        '{data: ch, valid: 1'b1, status: b64sc_pkg::STAT_OK};
                    res_n = res_n + b64sc_pkg::RES_CNT_BITS'(1);
                    if (wrap_on)
                    begin
                        line_column_next = line_column_next + COLUMN_BITS'(1);
                        if (line_column_next >= wrap_eff)
                        begin
                            res_list[res_n[b64sc_pkg::RES_IDX_BITS-1:0]] =
                                '{data: b64sc_pkg::CHAR_NL, valid: 1'b1,
                                  status: b64sc_pkg::STAT_OK};
                            res_n = res_n + b64sc_pkg::RES_CNT_BITS'(1);
                            line_column_next = '0;
                        end
                    end
                end
                group_bits_next = '0;
                group_fill_next = 2'd0;
            end
        end
        else
        begin
            priority if (item_byte_reg == b64sc_pkg::CHAR_NL)
                add = 1'b0;
            else if (item_byte_reg == b64sc_pkg::CHAR_PAD)
            begin
                if (pad_count_reg != 2'd3)
                    pad_count_next = pad_count_reg + 2'd1;
                add = 1'b1;
            end
            else if (sx[6])
            begin
                add   = 1'b1;
                add_v = sx[5:0];
            end
            else if (!ignore_garbage_reg)
            begin
                res_list[0] = '{data: 8'd0, valid: 1'b0, status: b64sc_pkg::STAT_BAD_CHAR};
                res_n       = b64sc_pkg::RES_CNT_BITS'(1);
            end

            if (add)
            begin
                unique case (group_fill_reg)
                    2'd0: group_bits_next = group_bits_reg | {add_v, 18'h0};
                    2'd1: group_bits_next = group_bits_reg | {6'h0, add_v, 12'h0};
                    2'd2: group_bits_next = group_bits_reg | {12'h0, add_v, 6'h0};
                    2'd3: group_bits_next = group_bits_reg | {18'h0, add_v};
                endcase
                if (group_fill_reg == 2'd3)
                begin
                    byte_cnt = 2'd3 - pad_count_next;
                    for (int k = 0; k < 3; k++)
                    begin
                        if (k < int'(byte_cnt))
                            res_list[k] = '{data: group_bits_next[23-8*k -: 8], valid: 1'b1,
                                            status: b64sc_pkg::STAT_OK};
                    end
                    res_n           = b64sc_pkg::RES_CNT_BITS'(byte_cnt);
                    group_bits_next = '0;
                    group_fill_next = 2'd0;
                    pad_count_next  = 2'd0;
                end
                else
                    group_fill_next = group_fill_reg + 2'd1;
            end

            if (item_last_reg)
            begin
                if (group_fill_next != 2'd0)
                begin
                    res_list[res_n[b64sc_pkg::RES_IDX_BITS-1:0]] =
                        '{data: 8'd0, valid: 1'b0, status: b64sc_pkg::STAT_INCOMPLETE};
                    res_n = res_n + b64sc_pkg::RES_CNT_BITS'(1);
                end
                group_bits_next = '0;
                group_fill_next = 2'd0;
                pad_count_next  = 2'd0;
            end
        end

        if (item_last_reg)
            line_column_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg  <= '0;
            group_fill_reg  <= 2'd0;
            pad_count_reg   <= 2'd0;
            line_column_reg <= '0;
        end
        else if (mode_clear)
        begin
            group_bits_reg  <= '0;
            group_fill_reg  <= 2'd0;
            pad_count_reg   <= 2'd0;
            line_column_reg <= '0;
        end
        else if (item_take)
        begin
            group_bits_reg  <= group_bits_next;
            group_fill_reg  <= group_fill_next;
            pad_count_reg   <= pad_count_next;
            line_column_reg <= line_column_next;
        end
    end

    always_comb
    begin
        res_load.load    = item_take && (res_n != '0);
        res_load.count   = res_n;
        res_load.entries = res_list;
    end

    b64sc_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (res_load),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .run_end    (run_end)
    );

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !item_take) |=>
            item_valid_reg && $stable(item_byte_reg) && $stable(item_last_reg))
        else $error("stalled item register lost its contents");

    a_data_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (status == b64sc_pkg::STAT_OK))
        else $error("data transaction carries a non-zero status");

endmodule

// File: design/b64sc_outq.sv
// ----------------------------------------------------------------------------
// b64sc_outq
// Result queue: takes one item's result list at once and hands it out one
// transaction per cycle, while out_ready is high, from a register at the head.
// ----------------------------------------------------------------------------
module b64sc_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  b64sc_pkg::res_load_t  load,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  byte_valid,
    output logic [1:0]            status,
    output logic                  run_end
);

    b64sc_pkg::res_entry_t                 entries_reg [b64sc_pkg::MAX_RESULTS];
    logic [b64sc_pkg::RES_CNT_BITS-1:0]    count_reg;
    logic [b64sc_pkg::RES_CNT_BITS-1:0]    count_next;
    logic                                  pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    // a new list may only land once the previous one is gone or its last entry is leaving
    assign can_load  = (count_reg == '0) ||
                       ((count_reg == b64sc_pkg::RES_CNT_BITS'(1)) && out_ready);

    always_comb
    begin
        if (load.load)
            count_next = load.count;
        else if (pop)
            count_next = count_reg - b64sc_pkg::RES_CNT_BITS'(1);
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (load.load)
        begin
            for (int i = 0; i < b64sc_pkg::MAX_RESULTS; i++)
                entries_reg[i] <= load.entries[i];
        end
        else if (pop)
        begin
            for (int i = 0; i < b64sc_pkg::MAX_RESULTS - 1; i++)
                entries_reg[i] <= entries_reg[i+1];
        end
    end

    assign out_byte   = entries_reg[0].data;
    assign byte_valid = entries_reg[0].valid;
    assign status     = entries_reg[0].status;
    // each list is loaded into an empty queue, so the final entry closes the run
    assign run_end    = (count_reg == b64sc_pkg::RES_CNT_BITS'(1));

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load.load |-> can_load)
        else $error("result list loaded over pending results");

    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load.load |-> (load.count != '0) &&
                      (load.count <= b64sc_pkg::RES_CNT_BITS'(b64sc_pkg::MAX_RESULTS)))
        else $error("result list count out of range");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !load.load) |=> (count_reg == $past(count_reg) - b64sc_pkg::RES_CNT_BITS'(1)))
        else $error("queue count did not drop after a transaction");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the base64 stream codec. A directed table covers the
// reset defaults, padding, wrapping extremes and the decode error statuses.
// Random phases follow, alternating encode and decode, with several register
// settings. Each output is checked against an in-bench predictor or table row.
// ----------------------------------------------------------------------------
module testbench;

    localparam string ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam logic [b64sc_pkg::CFG_INDEX_BITS-1:0] NO_REG = 2'd3;
    localparam int IDLE_PCT        = 14;
    localparam int N_PHASES        = 10;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int HOLD_AT         = 150;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 8;

    typedef struct packed {
        logic [7:0] ch;
        logic       has_byte;
        logic [1:0] stat;
        logic       run_end;
    } codec_res_t;

    typedef enum logic [1:0] {ROW_REG, ROW_PREDICT, ROW_TEXT, ROW_STATUS} row_kind_t;

    typedef struct {
        row_kind_t                            kind;
        logic [b64sc_pkg::CFG_INDEX_BITS-1:0] reg_idx;
        logic [b64sc_pkg::CFG_DATA_BITS-1:0]  value;
        bit                                   last;
        string                                text;
        logic [1:0]                           stat;
    } dir_row_t;

    // value holds the byte for item rows and the register data for ROW_REG
    dir_row_t directed_rows[$] = '{
        // encode at reset defaults (wrap 76)
        '{ROW_TEXT,    NO_REG, 10'h0FF, 1'b1, "/w==", b64sc_pkg::STAT_OK},
        '{ROW_TEXT,    NO_REG, 10'h000, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_TEXT,    NO_REG, 10'h000, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_TEXT,    NO_REG, 10'h0FF, 1'b1, "AAD/", b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h080, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h07F, 1'b1, "",     b64sc_pkg::STAT_OK},
        // narrowest wrap: a newline after every character, eight outputs
        '{ROW_REG, b64sc_pkg::REG_WRAP_COLUMNS, 10'd1, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h001, 1'b1, "",     b64sc_pkg::STAT_OK},
        '{ROW_REG, b64sc_pkg::REG_WRAP_COLUMNS, 10'd1023, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_REG, b64sc_pkg::REG_DECODE_MODE, 10'd1, 1'b0, "", b64sc_pkg::STAT_OK},
        // "TWFu"
        '{ROW_PREDICT, NO_REG, 10'h054, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h057, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h046, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h075, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_TEXT,    NO_REG, {2'b00, b64sc_pkg::CHAR_NL}, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_STATUS,  NO_REG, 10'h02A, 1'b0, "",     b64sc_pkg::STAT_BAD_CHAR},
        // "QQ==" gives a single byte
        '{ROW_PREDICT, NO_REG, 10'h051, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h051, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, {2'b00, b64sc_pkg::CHAR_PAD}, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, {2'b00, b64sc_pkg::CHAR_PAD}, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_STATUS,  NO_REG, 10'h07A, 1'b1, "",     b64sc_pkg::STAT_INCOMPLETE},
        // garbage silently dropped, pad still counts, unfinished group still flags
        '{ROW_REG, b64sc_pkg::REG_IGNORE_GARBAGE, 10'd1, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_TEXT,    NO_REG, 10'h000, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, {2'b00, b64sc_pkg::CHAR_PAD}, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h02B, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h02F, 1'b0, "",     b64sc_pkg::STAT_OK},
        '{ROW_STATUS,  NO_REG, 10'h0FF, 1'b1, "",     b64sc_pkg::STAT_INCOMPLETE},
        '{ROW_REG, b64sc_pkg::REG_WRAP_COLUMNS, 10'd0, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_REG, b64sc_pkg::REG_DECODE_MODE, 10'd0, 1'b0, "", b64sc_pkg::STAT_OK},
        '{ROW_PREDICT, NO_REG, 10'h0AA, 1'b1, "",     b64sc_pkg::STAT_OK}
    };

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_write;
    logic [b64sc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [b64sc_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                                 in_valid;
    logic                                 in_ready;
    logic [7:0]                           in_byte;
    logic                                 is_last;
    logic                                 out_valid;
    logic                                 out_ready;
    logic [7:0]                           out_byte;
    logic                                 byte_valid;
    logic [1:0]                           status;
    logic                                 run_end;

    // predictor state and register copy
    logic [23:0] grp_bits;
    int          grp_fill;
    int          pads_seen;
    logic [9:0]  line_col;
    bit          dec_mode;
    logic [9:0]  wrap_cols;
    bit          skip_garbage;

    codec_res_t  step_out[$];
    codec_res_t  pending_out[$];

    bit steady;
    int items_accepted;
    int outputs_checked;
    int reg_writes;
    int mismatches;

    base64_stream_codec u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .run_end    (run_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void add_result(input logic [7:0] ch, input bit has,
                                       input logic [1:0] st);
        if (step_out.size() < b64sc_pkg::MAX_RESULTS)
            step_out.push_back('{ch, has, st, 1'b0});
    endfunction

    function automatic void add_char(input logic [7:0] ch);
        add_result(ch, 1'b1, b64sc_pkg::STAT_OK);
        if (wrap_cols != 10'd0)
        begin
            line_col = line_col + 10'd1;
            if (line_col >= wrap_cols)
            begin
                add_result(b64sc_pkg::CHAR_NL, 1'b1, b64sc_pkg::STAT_OK);
                line_col = '0;
            end
        end
    endfunction

    function automatic int sextet_value(input logic [7:0] c);
        for (int i = 0; i < 64; i++)
            if (ALPHABET[i] == c)
                return i;
        return 64;
    endfunction

    function automatic void take_sextet(input logic [5:0] v);
        int n_bytes;
        grp_bits = grp_bits | (24'(v) << (18 - 6 * grp_fill));
        grp_fill++;
        if (grp_fill == 4)
        begin
            n_bytes = 3 - pads_seen;
            for (int k = 0; k < n_bytes; k++)
                add_result(8'(grp_bits >> (16 - 8 * k)), 1'b1, b64sc_pkg::STAT_OK);
            grp_bits  = '0;
            grp_fill  = 0;
            pads_seen = 0;
        end
    endfunction

    // works out the outputs of one input transaction into step_out
    function automatic void codec_step(input logic [7:0] b, input bit l);
        int         v;
        codec_res_t tail;
        step_out.delete();
        if (!dec_mode)
        begin
            grp_bits = grp_bits | (24'(b) << (16 - 8 * grp_fill));
            grp_fill++;
            if (grp_fill == 3 || l)
            begin
                for (int k = 0; k < 4; k++)
                    if (k > grp_fill)
                        add_char(b64sc_pkg::CHAR_PAD);
                    else
                        add_char(ALPHABET[6'(grp_bits >> (18 - 6 * k))]);
                grp_bits = '0;
                grp_fill = 0;
            end
        end
        else
        begin
            if (b == b64sc_pkg::CHAR_NL)
                v = 0;
            else if (b == b64sc_pkg::CHAR_PAD)
            begin
                if (pads_seen < 3)
                    pads_seen++;
                take_sextet(6'd0);
            end
            else
            begin
                v = sextet_value(b);
                if (v < 64)
                    take_sextet(6'(v));
                else if (!skip_garbage)
                    add_result(8'h00, 1'b0, b64sc_pkg::STAT_BAD_CHAR);
            end
            if (l)
            begin
                if (grp_fill != 0)
                    add_result(8'h00, 1'b0, b64sc_pkg::STAT_INCOMPLETE);
                grp_bits  = '0;
                grp_fill  = 0;
                pads_seen = 0;
            end
        end
        if (l)
            line_col = '0;
        if (step_out.size() > 0)
        begin
            tail = step_out.pop_back();
            tail.run_end = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    task automatic send_item(input logic [7:0] b, input bit l, input bit predicted);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        in_byte  <= b;
        is_last  <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_accepted++;
        codec_step(b, l);
        if (predicted)
            foreach (step_out[i])
                pending_out.push_back(step_out[i]);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [b64sc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [b64sc_pkg::CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        reg_writes++;
        if (idx == b64sc_pkg::REG_DECODE_MODE)
        begin
            dec_mode  = data[0];
            grp_bits  = '0;
            grp_fill  = 0;
            pads_seen = 0;
            line_col  = '0;
        end
        else if (idx == b64sc_pkg::REG_WRAP_COLUMNS)
            wrap_cols = data[9:0];
        else if (idx == b64sc_pkg::REG_IGNORE_GARBAGE)
            skip_garbage = data[0];
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // one message, ending with is_last; mostly well-formed in decode mode
    task automatic send_message(input bit decoding);
        logic [7:0] msg[$];
        int         len;
        int         groups;
        int         pads;
        int         pick;
        if (!decoding)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
            repeat (len)
            begin
                pick = $urandom_range(99);
                if (pick < 5)
                    msg.push_back(8'h00);
                else if (pick < 10)
                    msg.push_back(8'hFF);
                else
                    msg.push_back(8'($urandom_range(255)));
            end
        end
        else if ($urandom_range(99) < 80)
        begin
            groups = $urandom_range(1, 4);
            pads   = $urandom_range(0, 2);
            for (int g = 0; g < groups; g++)
                for (int c = 0; c < 4; c++)
                begin
                    if ($urandom_range(99) < 8)
                        msg.push_back(b64sc_pkg::CHAR_NL);
                    if (g == groups - 1 && c >= 4 - pads)
                        msg.push_back(b64sc_pkg::CHAR_PAD);
                    else
                        msg.push_back(ALPHABET[$urandom_range(63)]);
                end
        end
        else
        begin
            // noise and broken groups
            len = $urandom_range(1, 10);
            repeat (len)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    msg.push_back(ALPHABET[$urandom_range(63)]);
                else if (pick < 70)
                    msg.push_back(b64sc_pkg::CHAR_PAD);
                else if (pick < 80)
                    msg.push_back(b64sc_pkg::CHAR_NL);
                else
                    msg.push_back(8'($urandom_range(255)));
            end
        end
        foreach (msg[i])
            send_item(msg[i], i == msg.size() - 1, 1'b1);
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < 40)
            $display("%0t: mismatch: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Output side: ready pattern, including one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : check_results
        codec_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            outputs_checked++;
            if (pending_out.size() == 0)
                report_mismatch($sformatf("unexpected output byte %02h valid %0b status %0d",
                                          out_byte, byte_valid, status));
            else
            begin
                want = pending_out.pop_front();
                if (out_byte !== want.ch)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.ch));
                if (byte_valid !== want.has_byte)
                    report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                              byte_valid, want.has_byte));
                if (status !== want.stat)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.stat));
                if (run_end !== want.run_end)
                    report_mismatch($sformatf("run_end %0b, expected %0b",
                                              run_end, want.run_end));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("stalled for %0d cycles with %0d outputs outstanding",
                 STALL_LIMIT, pending_out.size());
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        dir_row_t                            row;
        int                                  first;
        logic [b64sc_pkg::CFG_DATA_BITS-1:0] wrap_pick;
        bit                                  ign_pick;

        steady          = 1'b0;
        items_accepted  = 0;
        outputs_checked = 0;
        reg_writes      = 0;
        mismatches      = 0;
        grp_bits        = '0;
        grp_fill        = 0;
        pads_seen       = 0;
        line_col        = '0;
        dec_mode        = 1'b0;
        wrap_cols       = b64sc_pkg::WRAP_RESET;
        skip_garbage    = 1'b0;

        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= b64sc_pkg::REG_DECODE_MODE;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_byte   <= 8'h00;
        is_last   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(row.reg_idx, row.value);
            end
            else
            begin
                send_item(row.value[7:0], row.last, row.kind == ROW_PREDICT);
                if (row.kind == ROW_TEXT)
                    for (int k = 0; k < row.text.len(); k++)
                        pending_out.push_back('{row.text[k], 1'b1, b64sc_pkg::STAT_OK,
                                                k == row.text.len() - 1});
                else if (row.kind == ROW_STATUS)
                    pending_out.push_back('{8'h00, 1'b0, row.stat, 1'b1});
            end
        end

        // random phases: even ones encode, odd ones decode
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            steady = (ph == 2);
            unique case (ph)
                0:       wrap_pick = 10'd1;
                2:       wrap_pick = 10'($urandom_range(2, 12));
                4:       wrap_pick = 10'd0;
                6:       wrap_pick = 10'd76;
                8:       wrap_pick = 10'd1023;
                default: wrap_pick = 10'($urandom_range(1023));
            endcase
            if (ph % 2 == 0 || ph == 9)
                ign_pick = 1'($urandom_range(1));
            else
                ign_pick = ((ph / 2) % 2 == 1);
            write_reg(b64sc_pkg::REG_DECODE_MODE, b64sc_pkg::CFG_DATA_BITS'(ph % 2));
            write_reg(b64sc_pkg::REG_WRAP_COLUMNS, wrap_pick);
            write_reg(b64sc_pkg::REG_IGNORE_GARBAGE, b64sc_pkg::CFG_DATA_BITS'(ign_pick));
            first = items_accepted;
            while (items_accepted - first < ITEMS_PER_PHASE)
                send_message(ph % 2 == 1);
        end
        steady = 1'b0;

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input transactions over directed and %0d random phases,",
                 items_accepted, N_PHASES);
        $display("checked %0d output transactions after %0d register writes.",
                 outputs_checked, reg_writes);
        if (mismatches == 0 && pending_out.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
